### src/clsrw_pkg.sv
// Package for the character LCD shift-register writer.
// Holds the request, queue-entry, segment and register types and shared constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package clsrw_pkg;

  // Width of the byte shifted out to the display.
  localparam int unsigned DATA_BITS = 8;
  localparam int unsigned BIT_CNT_W = $clog2(DATA_BITS);

  // Depth of the queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned HOLD_W      = 16;

  // Register reset values.
  localparam logic [HOLD_W-1:0] CLOCK_HIGH_RESET  = HOLD_W'(1000);
  localparam logic [HOLD_W-1:0] ENABLE_HIGH_RESET = HOLD_W'(450);
  localparam logic [HOLD_W-1:0] ENABLE_LOW_RESET  = HOLD_W'(40);

  // Register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLOCK_HIGH  = 2'd0,
    CFG_ENABLE_HIGH = 2'd1,
    CFG_ENABLE_LOW  = 2'd2
  } cfg_index_t;

  // Request function codes; unlisted codes behave as a raw command.
  typedef enum logic [3:0] {
    FUNC_RAW     = 4'd0,
    FUNC_CLEAR   = 4'd1,
    FUNC_HOME    = 4'd2,
    FUNC_MODE    = 4'd3,
    FUNC_DISPLAY = 4'd4,
    FUNC_SHIFT   = 4'd5,
    FUNC_FUNCSET = 4'd6,
    FUNC_CGRAM   = 4'd7,
    FUNC_DDRAM   = 4'd8,
    FUNC_DATA    = 4'd9
  } func_t;

  // Input request.
  typedef struct packed {
    logic [3:0] func;
    logic [7:0] arg;
  } req_t;

  // One output segment: pin levels and how long they are held.
  typedef struct packed {
    logic              shift_clock;
    logic              serial_line;
    logic              enable_line;
    logic [HOLD_W-1:0] hold_us;
    logic              last;
  } seg_t;

  // Classified request as it waits in the queue.
  typedef struct packed {
    logic [DATA_BITS-1:0] data_byte;
    logic                 sel;
  } entry_t;

  // Handshake between a producer and a consumer of queue entries.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } entry_chan_t;

  // Timing registers.
  typedef struct packed {
    logic [HOLD_W-1:0] clock_high_us;
    logic [HOLD_W-1:0] enable_high_us;
    logic [HOLD_W-1:0] enable_low_us;
  } cfg_regs_t;

endpackage

`default_nettype wire

### src/clsrw_front.sv
// Front part of the LCD writer: accepts requests and forms the display byte.
// Depends on clsrw_pkg; feeds clsrw_queue.
`default_nettype none

module clsrw_front
  import clsrw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire req_t        in_data,
  input  wire logic        queue_full,
  output entry_chan_t      push
);

  logic   f_valid;
  entry_t f_entry;
  logic   accept;
  logic   pushed;
  entry_t formed;

  // Mask the argument and merge the opcode for the command codes; data and unlisted codes pass the argument as is.
  function automatic entry_t form_entry(input req_t r);
    entry_t e;
    e.sel = 1'b0;
    case (r.func)
      FUNC_CLEAR:   e.data_byte = 8'h01;
      FUNC_HOME:    e.data_byte = 8'h02;
      FUNC_MODE:    e.data_byte = (r.arg & 8'h03) | 8'h04;
      FUNC_DISPLAY: e.data_byte = (r.arg & 8'h07) | 8'h08;
      FUNC_SHIFT:   e.data_byte = (r.arg & 8'h0f) | 8'h10;
      FUNC_FUNCSET: e.data_byte = (r.arg & 8'h0c) | 8'h30;
      FUNC_CGRAM:   e.data_byte = (r.arg & 8'h3f) | 8'h40;
      FUNC_DDRAM:   e.data_byte = (r.arg & 8'h7f) | 8'h80;
      FUNC_DATA: begin
        e.data_byte = r.arg;
        e.sel       = 1'b1;
      end
      default:      e.data_byte = r.arg;
    endcase
    return e;
  endfunction

  assign formed   = form_entry(in_data);
  assign pushed   = f_valid && !queue_full;
  assign in_stall = f_valid && queue_full;
  assign accept   = in_valid && !in_stall;

  assign push.valid = pushed;
  assign push.entry = f_entry;

  // Single holding stage for a classified request.
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (pushed) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_entry <= formed;
    end
  end

endmodule

`default_nettype wire

### src/clsrw_queue.sv
// Short queue of classified requests between the front and the back.
// Depends on clsrw_pkg.
`default_nettype none

module clsrw_queue
  import clsrw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire entry_chan_t push,
  output logic             full,
  output entry_chan_t      head,
  input  wire logic        pop
);

  entry_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not rise on push");
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not fall on pop");
`endif

endmodule

`default_nettype wire

### src/clsrw_back.sv
// Back part of the LCD writer: turns each queued byte into 28 timed pin segments.
// Depends on clsrw_pkg; reads clsrw_queue and the timing registers.
`default_nettype none

module clsrw_back
  import clsrw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire entry_chan_t head,
  output logic             pop,
  input  wire cfg_regs_t   cfg,
  output logic             out_valid,
  input  wire logic        out_stall,
  output seg_t             out_data
);

  typedef enum logic [4:0] {
    ST_START = 5'b00001,
    ST_BITS  = 5'b00010,
    ST_SEL   = 5'b00100,
    ST_EN_HI = 5'b01000,
    ST_EN_LO = 5'b10000
  } state_t;

  state_t               state, state_next;
  logic [DATA_BITS-1:0] shreg, shreg_next;
  logic                 sel, sel_next;
  logic [BIT_CNT_W-1:0] bit_cnt, bit_cnt_next;
  logic [1:0]           phase, phase_next;
  logic                 serial_level, serial_level_next;
  logic                 advance;
  logic                 emit;
  seg_t                 seg;

  assign advance = !out_valid || !out_stall;

  // Segment sequencer: one segment per cycle while the output register is free.
  always_comb begin
    state_next        = state;
    shreg_next        = shreg;
    sel_next          = sel;
    bit_cnt_next      = bit_cnt;
    phase_next        = phase;
    serial_level_next = serial_level;
    emit              = 1'b0;
    pop               = 1'b0;
    seg               = '0;
    seg.serial_line   = serial_level;
    case (state)
      ST_START: begin
        if (head.valid) begin
          emit         = 1'b1;
          pop          = advance;
          shreg_next   = head.entry.data_byte;
          sel_next     = head.entry.sel;
          bit_cnt_next = '0;
          phase_next   = 2'd0;
          state_next   = ST_BITS;
        end
      end
      ST_BITS: begin
        emit              = 1'b1;
        seg.serial_line   = shreg[DATA_BITS-1];
        serial_level_next = shreg[DATA_BITS-1];
        if (phase == 2'd1) begin
          seg.shift_clock = 1'b1;
          seg.hold_us     = cfg.clock_high_us;
        end
        if (phase == 2'd2) begin
          phase_next = 2'd0;
          shreg_next = {shreg[DATA_BITS-2:0], 1'b0};
          if (bit_cnt == BIT_CNT_W'(DATA_BITS - 1)) begin
            state_next = ST_SEL;
          end else begin
            bit_cnt_next = bit_cnt + 1'b1;
          end
        end else begin
          phase_next = phase + 2'd1;
        end
      end
      ST_SEL: begin
        emit              = 1'b1;
        seg.serial_line   = sel;
        serial_level_next = sel;
        state_next        = ST_EN_HI;
      end
      ST_EN_HI: begin
        emit            = 1'b1;
        seg.enable_line = 1'b1;
        seg.hold_us     = cfg.enable_high_us;
        state_next      = ST_EN_LO;
      end
      ST_EN_LO: begin
        emit        = 1'b1;
        seg.hold_us = cfg.enable_low_us;
        seg.last    = 1'b1;
        state_next  = ST_START;
      end
      default: begin
        state_next = ST_START;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_START;
      serial_level <= 1'b0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      state        <= state_next;
      serial_level <= serial_level_next;
      out_valid    <= emit;
    end
  end

  // Working registers and the output segment.
  always_ff @(posedge clk) begin
    if (advance) begin
      shreg   <= shreg_next;
      sel     <= sel_next;
      bit_cnt <= bit_cnt_next;
      phase   <= phase_next;
      if (emit) begin
        out_data <= seg;
      end
    end
  end

`ifndef ASSERT_OFF
  a_last_idle_pins: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.last) |-> (!out_data.shift_clock && !out_data.enable_line))
    else $error("final segment leaves clock or enable high");
  a_enable_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.enable_line) |-> (out_data.hold_us == cfg.enable_high_us))
    else $error("enable pulse has the wrong hold");
  a_clock_not_enable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.shift_clock) |-> !out_data.enable_line)
    else $error("shift clock and enable high together");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

### src/char_lcd_shift_register_writer.sv
// Character LCD writer through a serial-in shift register.
// Each request (func, arg) on the input channel becomes a display byte that is
// sent as 28 pin segments on the output channel: clock low, then for each of
// the 8 bits, MSB first, data set / clock high / clock low, then the
// register-select level on the shared serial line and an enable pulse.
// hold_us on each segment is the time the host keeps those levels; last marks
// the final segment of a request.
// The first segment of a request passes the holding stage, the queue and the
// output register of the back sequencer in that order when the block is empty.
// The back sequencer emits one segment per cycle while the output is not
// stalled; a two-entry queue plus a holding stage let up to three requests
// wait while the back is busy.
// Output stall freezes the sequencer and the output register; the input side
// stalls only once the queue and the holding stage are full.
// The timing registers are written through cfg_valid/cfg_ready (always ready)
// and must only change while no request is in flight.
// Reset (rst, synchronous) empties the queue, returns the sequencer to its start
// state, sets the serial level to 0 and loads the default timing values.
// Depends on clsrw_pkg, clsrw_front, clsrw_queue and clsrw_back.
`default_nettype none

module char_lcd_shift_register_writer
  import clsrw_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire req_t                   in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output seg_t                        out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [HOLD_W-1:0]      cfg_data
);

  cfg_regs_t   cfg;
  entry_chan_t push;
  entry_chan_t head;
  logic        queue_full;
  logic        pop;

  assign cfg_ready = 1'b1;

  // Timing registers; writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clock_high_us  <= CLOCK_HIGH_RESET;
      cfg.enable_high_us <= ENABLE_HIGH_RESET;
      cfg.enable_low_us  <= ENABLE_LOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CLOCK_HIGH:  cfg.clock_high_us  <= cfg_data;
        CFG_ENABLE_HIGH: cfg.enable_high_us <= cfg_data;
        CFG_ENABLE_LOW:  cfg.enable_low_us  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  clsrw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .queue_full (queue_full),
    .push       (push)
  );

  clsrw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  clsrw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
